/* sv/lrdc_pkg.sv */
// Shared types and constants for the L/R decimal command parser.
// No dependencies; imported by every module of the block.
package lrdc_pkg;

   // Command characters.
   localparam logic [7:0] CHAR_L  = 8'h4C;
   localparam logic [7:0] CHAR_R  = 8'h52;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   // Parser modes.
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_LEFT  = 2'd1;
   localparam logic [1:0] MODE_RIGHT = 2'd2;
   localparam logic [1:0] MODE_ERROR = 2'd3;

   // Conversion phases within one field.
   localparam logic [1:0] PH_SPACE = 2'd0;
   localparam logic [1:0] PH_SIGN  = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   typedef struct packed {
      logic [1:0]  phase;
      logic        negative;
      logic [15:0] acc;
   } lrdc_field_type;

   typedef struct packed {
      logic               emit;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
   } lrdc_result_type;

endpackage

/* sv/lrdc_char_step.sv */
// Conversion of one field character: whitespace skip, sign, decimal digits.
// Depends on lrdc_pkg for the phase codes and the field state type.
module lrdc_char_step (
   input  lrdc_pkg::lrdc_field_type field_cur,
   input  logic [7:0]               rx_byte,
   output lrdc_pkg::lrdc_field_type field_next
);
   import lrdc_pkg::*;

   logic        is_digit;
   logic        is_space;
   logic [15:0] digit_val;
   logic [15:0] acc_times_ten;

   assign is_digit  = rx_byte inside {[8'h30:8'h39]};
   assign is_space  = rx_byte inside {8'h20, [8'h09:8'h0C]};
   // ASCII digits sit at 0x30..0x39, so the low nibble is the value.
   assign digit_val = {12'd0, rx_byte[3:0]};
   assign acc_times_ten = {field_cur.acc[12:0], 3'b000} + {field_cur.acc[14:0], 1'b0};

   always_comb begin
      field_next = field_cur;
      case (field_cur.phase)
         PH_SPACE: begin
            if (is_space) begin
               field_next.phase = PH_SPACE;
            end else if (rx_byte == 8'h2B || rx_byte == 8'h2D) begin
               field_next.negative = (rx_byte == 8'h2D);
               field_next.phase    = PH_SIGN;
            end else if (is_digit) begin
               field_next.acc   = digit_val;
               field_next.phase = PH_DIGIT;
            end else begin
               field_next.phase = PH_DONE;
            end
         end
         PH_SIGN, PH_DIGIT: begin
            if (is_digit) begin
               field_next.acc   = acc_times_ten + digit_val;
               field_next.phase = PH_DIGIT;
            end else begin
               field_next.phase = PH_DONE;
            end
         end
         default: begin
            field_next = field_cur;
         end
      endcase
   end

endmodule

/* sv/lrdc_parse_core.sv */
// Command state of the parser: mode, character count, field and left value.
// Depends on lrdc_pkg and lrdc_char_step.
module lrdc_parse_core #(
   parameter int LINE_BUFFER_SIZE = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                rx_byte,
   output lrdc_pkg::lrdc_result_type result
);
   import lrdc_pkg::*;

   localparam int CountWidth = $clog2(LINE_BUFFER_SIZE + 1);

   logic [1:0]            mode_ff, mode_in;
   logic [CountWidth-1:0] count_ff, count_in;
   lrdc_field_type        field_ff, field_in;
   logic [15:0]           left_ff, left_in;
   lrdc_field_type        field_step;
   logic [CountWidth-1:0] count_inc;
   logic [15:0]           field_value;
   logic                  capturing;

   lrdc_char_step u_char_step (
      .field_cur  (field_ff),
      .rx_byte    (rx_byte),
      .field_next (field_step)
   );

   assign count_inc   = count_ff + CountWidth'(1);
   assign field_value = field_ff.negative ? (16'd0 - field_ff.acc) : field_ff.acc;
   assign capturing   = (mode_ff == MODE_LEFT) || (mode_ff == MODE_RIGHT);

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      field_in = field_ff;
      left_in  = left_ff;
      result.emit        = 1'b0;
      result.left_speed  = left_ff;
      result.right_speed = field_value;
      if (step) begin
         if (rx_byte == CHAR_L || rx_byte == CHAR_R) begin
            // Either command letter restarts capture from a clean field.
            mode_in  = (rx_byte == CHAR_L) ? MODE_LEFT : MODE_RIGHT;
            count_in = '0;
            field_in = '{phase: PH_SPACE, negative: 1'b0, acc: 16'd0};
         end else if (capturing) begin
            if (rx_byte != CHAR_CR) begin
               field_in = field_step;
               count_in = count_inc;
               if (count_inc >= CountWidth'(LINE_BUFFER_SIZE)) begin
                  mode_in = MODE_ERROR;
               end
            end else if (mode_ff == MODE_LEFT) begin
               left_in = field_value;
               mode_in = MODE_IDLE;
            end else begin
               result.emit = 1'b1;
               mode_in     = MODE_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
         field_ff <= '{phase: PH_SPACE, negative: 1'b0, acc: 16'd0};
         left_ff  <= 16'd0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         field_ff <= field_in;
         left_ff  <= left_in;
      end
   end

endmodule

/* sv/lr_decimal_command_parser.sv */
// Channel   Direction  Payload                                   Handshake
// req_      in         rx_byte (8 bits, ASCII)                   req_valid / req_stall
// rsp_      out        left_speed, right_speed (16 bits, signed) rsp_valid / rsp_stall
//
// Each received byte is captured in the input register; the parser state and the result
// register update when that byte is stepped, so a result is presented from the result register
// after the byte's transfer. One byte is taken every cycle while the result side keeps up.
// req_stall rises only while a held result is stalled and the input register is full.
// Synchronous reset returns to idle with a stored left value of zero.
// Depends on lrdc_pkg and lrdc_parse_core.
module lr_decimal_command_parser #(
   parameter int LINE_BUFFER_SIZE = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_left_speed,
   output logic signed [15:0] rsp_right_speed
);
   import lrdc_pkg::*;

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               out_valid_ff, out_valid_in;
   logic signed [15:0] out_left_ff;
   logic signed [15:0] out_right_ff;
   logic               advance;
   logic               step;
   lrdc_result_type    result;

   // The parse stage moves whenever the result register is free or being drained.
   assign advance   = !(out_valid_ff && rsp_stall);
   assign step      = advance && in_valid_ff;
   assign req_stall = in_valid_ff && !advance;

   lrdc_parse_core #(
      .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
   ) u_parse_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   assign out_valid_in = advance ? (step && result.emit) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
      if (step && result.emit) begin
         out_left_ff  <= result.left_speed;
         out_right_ff <= result.right_speed;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_left_speed  = out_left_ff;
   assign rsp_right_speed = out_right_ff;

   // A result produced by the parse stage must be presented on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      step && result.emit |=> rsp_valid)
      else $error("result lost between parse stage and output register");

   // The input side may only be held back by a stalled, pending result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // A command letter never completes a field, so no result follows it.
   assert property (@(posedge clock) disable iff (reset)
      step && (in_byte_ff == CHAR_L || in_byte_ff == CHAR_R) |=> !rsp_valid)
      else $error("result produced by a command letter");

endmodule
